/* rtl/core/crc32_combine_core_defines.svh */
// Assertion macros for the CRC-32 combine core.
// Both expect signals named clock and reset in the calling scope.
`ifndef CRC32_COMBINE_CORE_DEFINES_SVH
`define CRC32_COMBINE_CORE_DEFINES_SVH

// same-cycle implication
`define C32_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c32cmb: check failed");

// next-cycle implication
`define C32_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c32cmb: check failed");

`endif

/* rtl/core/c32cmb_pkg.sv */
`timescale 1ns / 1ps

package c32cmb_pkg;

   localparam int CRC_W       = 32;
   localparam int MAT_DIM     = 32;
   localparam int LEN_W       = 32;            // width of the length field
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

   // low length bits taken into account (1..64); bits beyond the field are zero
   localparam int LENGTH_BITS = 32;
   localparam int USED_BITS   = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
   localparam int IDX_W       = (USED_BITS > 1) ? $clog2(USED_BITS) : 1;

   typedef logic [MAT_DIM-1:0][CRC_W-1:0]   op_mat_type;
   typedef logic [USED_BITS-1:0][MAT_DIM-1:0][CRC_W-1:0] op_tab_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // length shifter status towards the control
   typedef struct packed {
      logic             bit_now;  // current length bit
      logic [IDX_W-1:0] idx;      // its position
      logic             empty;    // no set bits remain
   } len_stat_type;

   function automatic logic [CRC_W-1:0] gf2_apply(input op_mat_type m,
                                                  input logic [CRC_W-1:0] v);
      logic [CRC_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < MAT_DIM; i++) begin
         if (v[i]) begin
            acc = acc ^ m[i];
         end
      end
      return acc;
   endfunction

   function automatic op_mat_type gf2_square(input op_mat_type m);
      op_mat_type r;
      for (int i = 0; i < MAT_DIM; i++) begin
         r[i] = gf2_apply(m, m[i]);
      end
      return r;
   endfunction

   // entry k advances a CRC through 2**k zero bytes
   function automatic op_tab_type build_op_table();
      op_tab_type t;
      op_mat_type op;
      op[0] = CRC_POLY;
      for (int i = 1; i < MAT_DIM; i++) begin
         op[i] = CRC_W'(1) << (i - 1);
      end
      for (int i = 0; i < 3; i++) begin
         op = gf2_square(op);
      end
      t[0] = op;
      for (int k = 1; k < USED_BITS; k++) begin
         op = gf2_square(op);
         t[k] = op;
      end
      return t;
   endfunction

   localparam op_tab_type OP_TABLE = build_op_table();

endpackage

/* rtl/core/c32cmb_len_shift.sv */
`timescale 1ns / 1ps

// Length shift register: one length bit per cycle while shift is asserted, LSB first.
module c32cmb_len_shift
   import c32cmb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [USED_BITS-1:0] load_value,
   input  logic                 shift,
   output len_stat_type         stat
);

   logic [USED_BITS-1:0] len_ff, len_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   always_comb begin
      len_in = len_ff;
      idx_in = idx_ff;
      if (load) begin
         len_in = load_value;
         idx_in = '0;
      end else if (shift) begin
         len_in = len_ff >> 1;
         idx_in = idx_ff + IDX_W'(1);   // wraps only once len is empty
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         idx_ff <= '0;
      end else begin
         len_ff <= len_in;
         idx_ff <= idx_in;
      end
   end

   assign stat.bit_now = len_ff[0];
   assign stat.idx     = idx_ff;
   assign stat.empty   = (len_ff == '0);

endmodule

/* rtl/core/c32cmb_op_apply.sv */
`timescale 1ns / 1ps

// GF(2) operator application: crc times the zero-byte operator for bit idx.
module c32cmb_op_apply
   import c32cmb_pkg::*;
(
   input  logic [CRC_W-1:0] crc,
   input  logic [IDX_W-1:0] idx,
   output logic [CRC_W-1:0] crc_adv
);

   op_mat_type mat;

   always_comb begin
      mat     = OP_TABLE[idx];
      crc_adv = gf2_apply(mat, crc);
   end

endmodule

/* rtl/core/crc32_combine_core.sv */
// Channel | Ports                                          | Direction
// --------+------------------------------------------------+----------
// request | req_valid/ready, req_first_crc, req_second_crc,| in
//         | req_second_length                              |
// response| rsp_valid/ready, rsp_joined_crc                | out
//
// One transaction at a time. After acceptance the core steps through the
// length bits, one length bit per cycle, up to the highest set bit (length
// shift register, combinational 32x32 GF(2) operator apply), then loads the
// result register. A zero length goes straight to loading the result register.
// Synchronous active-high reset empties the core; no clearing pass.
// A stalled response holds the finished CRC in the loop until the result
// register frees; a new request is taken while a result waits.
`timescale 1ns / 1ps

module crc32_combine_core
   import c32cmb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CRC_W-1:0] req_first_crc,
   input  logic [CRC_W-1:0] req_second_crc,
   input  logic [LEN_W-1:0] req_second_length,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CRC_W-1:0] rsp_joined_crc
);

`include "crc32_combine_core_defines.svh"

   state_type        state_ff, state_in;
   logic [CRC_W-1:0] crc_ff, crc_in;        // first CRC being advanced
   logic [CRC_W-1:0] crc_b_ff, crc_b_in;    // second CRC, XORed at the end
   logic             zero_ff, zero_in;      // zero length: pass first CRC as is
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0] rsp_crc_ff, rsp_crc_in;

   logic             req_take;
   logic             slot_free;
   logic             finish;
   logic             shift;
   logic [CRC_W-1:0] crc_adv;
   len_stat_type     len_stat;

   c32cmb_len_shift u_len (
      .clock      (clock),
      .reset      (reset),
      .load       (req_take),
      .load_value (req_second_length[USED_BITS-1:0]),
      .shift      (shift),
      .stat       (len_stat)
   );

   c32cmb_op_apply u_apply (
      .crc     (crc_ff),
      .idx     (len_stat.idx),
      .crc_adv (crc_adv)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      crc_in       = crc_ff;
      crc_b_in     = crc_b_ff;
      zero_in      = zero_ff;
      rsp_crc_in   = rsp_crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      shift        = 1'b0;
      finish       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               crc_in   = req_first_crc;
               crc_b_in = req_second_crc;
               zero_in  = (req_second_length[USED_BITS-1:0] == '0);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!len_stat.empty) begin
               // one length bit per cycle
               shift = 1'b1;
               if (len_stat.bit_now) begin
                  crc_in = crc_adv;
               end
            end else if (slot_free) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_crc_in   = zero_ff ? crc_ff : (crc_ff ^ crc_b_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff     <= crc_in;
      crc_b_ff   <= crc_b_in;
      zero_ff    <= zero_in;
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_joined_crc = rsp_crc_ff;

   // accepted request always starts the loop
   `C32_ASSERT_NXT(a_take_runs, req_take, state_ff == ST_RUN)
   // finishing fills the result register and frees the core
   `C32_ASSERT_NXT(a_finish_out, finish, rsp_valid_ff && state_ff == ST_IDLE)
   // a done loop facing a stalled result must keep waiting, not drop it
   `C32_ASSERT_NXT(a_wait_hold,
      state_ff == ST_RUN && len_stat.empty && rsp_valid_ff && !rsp_ready,
      state_ff == ST_RUN && len_stat.empty)

endmodule
